// File: sv/lccop_pkg.sv
`timescale 1ns / 1ps
package lccop_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int ADC_BITS    = 12;
    localparam int OFF_BITS    = 12;
    localparam int GAIN_BITS   = 16;
    localparam int POS_BITS    = 8;
    localparam int CH_W        = $clog2(NUM_SENSORS);

    localparam int DIFF_W = ((ADC_BITS > OFF_BITS) ? ADC_BITS : OFF_BITS) + 1;
    localparam int RAW_W  = DIFF_W + GAIN_BITS;
    localparam int TARE_W = RAW_W + 1;
    localparam int F_W    = RAW_W + 2;
    localparam int W_W    = RAW_W + 3;
    localparam int PROD_W = F_W + POS_BITS;
    localparam int MOM_W  = PROD_W + 3;
    localparam int BAL_W  = F_W + 3;
    localparam int NUM_W  = MOM_W + 9;

    localparam int BAL_SHIFT = 14;
    localparam int CEN_SHIFT = 8;

    // 16 magnitude bits plus one saturation bit
    localparam int QUO_BITS   = 17;
    localparam int STEP_W     = 5;
    localparam int NUM_RATIOS = 10;
    localparam int RIDX_W     = 4;

    localparam int RES_W    = 16;
    localparam int WEIGHT_W = 32;
    localparam int THR_W    = 31;

    localparam logic [17:0] BAL_LIM     = 18'd16384;
    localparam logic [17:0] CEN_POS_LIM = 18'd32767;
    localparam logic [17:0] CEN_NEG_LIM = 18'd32768;

    localparam logic [2:0] REG_OFF_LO  = 3'd0;
    localparam logic [2:0] REG_OFF_HI  = 3'd1;
    localparam logic [2:0] REG_GAIN_LO = 3'd2;
    localparam logic [2:0] REG_GAIN_HI = 3'd3;
    localparam logic [2:0] REG_XPOS    = 3'd4;
    localparam logic [2:0] REG_YPOS    = 3'd5;
    localparam logic [2:0] REG_FALL    = 3'd6;

    localparam logic [THR_W-1:0] FALL_RESET = 31'd75341;

    localparam logic [RIDX_W-1:0] R_LAT   = 4'd0;
    localparam logic [RIDX_W-1:0] R_FA    = 4'd1;
    localparam logic [RIDX_W-1:0] R_TW    = 4'd2;
    localparam logic [RIDX_W-1:0] R_CX    = 4'd3;
    localparam logic [RIDX_W-1:0] R_CY    = 4'd4;
    localparam logic [RIDX_W-1:0] R_ROT   = 4'd5;
    localparam logic [RIDX_W-1:0] R_LX    = 4'd6;
    localparam logic [RIDX_W-1:0] R_LY    = 4'd7;
    localparam logic [RIDX_W-1:0] R_RX    = 4'd8;
    localparam logic [RIDX_W-1:0] R_RY    = 4'd9;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_TARE    = 2'd1,
        OP_CAL     = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_FORCE,
        S_MOMENT,
        S_SUMS,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ADC_BITS-1:0] sample_0;
        logic [ADC_BITS-1:0] sample_1;
        logic [ADC_BITS-1:0] sample_2;
        logic [ADC_BITS-1:0] sample_3;
        logic [ADC_BITS-1:0] sample_4;
        logic [ADC_BITS-1:0] sample_5;
        logic [ADC_BITS-1:0] sample_6;
        logic [ADC_BITS-1:0] sample_7;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] lateral_balance;
        logic signed [15:0] fore_aft_balance;
        logic signed [15:0] twist_balance;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_rotation;
        logic signed [15:0] left_center_x;
        logic signed [15:0] left_center_y;
        logic signed [15:0] right_center_x;
        logic signed [15:0] right_center_y;
        logic signed [31:0] total_weight;
        logic               fall_flag;
    } t_out_item;

    typedef struct packed {
        logic [47:0]      off_lo;
        logic [47:0]      off_hi;
        logic [63:0]      gain_lo;
        logic [63:0]      gain_hi;
        logic [63:0]      xpos;
        logic [63:0]      ypos;
        logic [THR_W-1:0] fall;
    } t_cfg;

    typedef struct packed {
        logic              load_in;
        logic              raw_step;
        logic              force_step;
        logic              mom_step;
        logic              sums;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic [CH_W-1:0]   ch;
        logic [STEP_W-1:0] step;
        logic [RIDX_W-1:0] ridx;
    } t_cmd;

    typedef struct packed {
        t_op op;
    } t_status;

endpackage

// File: sv/load_cell_center_of_pressure_top.sv
`timescale 1ns / 1ps
// A measure runs a raw pass, a force pass and a moment pass over the 8 sensors,
// a sum step, then 10 ratios on one shared bit-serial divider, and a load into the
// output register. Only one request is taken at a time; a measure frees the input
// once its result is in the output register, other opcodes once their force pass ends.
// Reset is synchronous, active low: clears control and the stored zero and tare
// forces, and returns config registers to their defaults.
module load_cell_center_of_pressure_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lccop_pkg::t_in_item  i_in_item,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lccop_pkg::t_out_item o_out_item,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import lccop_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_cmd      w_cmd;
    t_status   w_status;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_out_load;
    logic      w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[5:3];

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= {{($bits(t_cfg) - THR_W){1'b0}}, FALL_RESET};
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OFF_LO:  r_cfg.off_lo  <= pwdata[47:0];
                REG_OFF_HI:  r_cfg.off_hi  <= pwdata[47:0];
                REG_GAIN_LO: r_cfg.gain_lo <= pwdata;
                REG_GAIN_HI: r_cfg.gain_hi <= pwdata;
                REG_XPOS:    r_cfg.xpos    <= pwdata;
                REG_YPOS:    r_cfg.ypos    <= pwdata;
                REG_FALL:    r_cfg.fall    <= pwdata[THR_W-1:0];
                default:     r_cfg.fall    <= r_cfg.fall;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OFF_LO:  prdata = 64'(r_cfg.off_lo);
            REG_OFF_HI:  prdata = 64'(r_cfg.off_hi);
            REG_GAIN_LO: prdata = r_cfg.gain_lo;
            REG_GAIN_HI: prdata = r_cfg.gain_hi;
            REG_XPOS:    prdata = r_cfg.xpos;
            REG_YPOS:    prdata = r_cfg.ypos;
            REG_FALL:    prdata = 64'(r_cfg.fall);
            default:     prdata = '0;
        endcase
    end

    // output register: free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) r_out_item <= w_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    lccop_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall),
        .o_out_load (w_out_load)
    );

    lccop_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (r_cfg),
        .i_item   (i_in_item),
        .o_status (w_status),
        .o_result (w_result)
    );

endmodule

// File: sv/lccop_ctrl.sv
`timescale 1ns / 1ps
module lccop_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  lccop_pkg::t_status i_status,
    output lccop_pkg::t_cmd   o_cmd,
    output logic              o_in_stall,
    output logic              o_out_load
);
    import lccop_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [RIDX_W-1:0] r_ridx, n_ridx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ridx  <= n_ridx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ridx  = r_ridx;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_RAW;
            end
            S_RAW: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(NUM_SENSORS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FORCE;
                end
            end
            S_FORCE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(NUM_SENSORS - 1)) begin
                    n_cnt   = '0;
                    n_state = (i_status.op == OP_MEASURE) ? S_MOMENT : S_IDLE;
                end
            end
            S_MOMENT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(NUM_SENSORS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SUMS;
                end
            end
            S_SUMS: begin
                n_ridx  = '0;
                n_state = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                n_cnt   = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(QUO_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV_STORE;
                end
            end
            S_DIV_STORE: begin
                if (r_ridx == RIDX_W'(NUM_RATIOS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_ridx  = r_ridx + 1'b1;
                    n_state = S_DIV_LOAD;
                end
            end
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.ch         = r_cnt[CH_W-1:0];
        o_cmd.step       = r_cnt;
        o_cmd.ridx       = r_ridx;
        o_in_stall       = (r_state != S_IDLE);
        o_out_load       = 1'b0;
        unique case (r_state)
            S_IDLE:      o_cmd.load_in    = i_in_valid;
            S_RAW:       o_cmd.raw_step   = 1'b1;
            S_FORCE:     o_cmd.force_step = 1'b1;
            S_MOMENT:    o_cmd.mom_step   = 1'b1;
            S_SUMS:      o_cmd.sums       = 1'b1;
            S_DIV_LOAD:  o_cmd.div_load   = 1'b1;
            S_DIV_STEP:  o_cmd.div_step   = 1'b1;
            S_DIV_STORE: o_cmd.div_store  = 1'b1;
            S_OUT:       o_out_load       = i_out_free;
            default:     o_out_load       = 1'b0;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RAW))
        else $error("accepted request did not start the raw pass");

    a_raw_to_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAW && r_cnt == STEP_W'(NUM_SENSORS - 1)) |=> (r_state == S_FORCE))
        else $error("raw pass did not hand over to force pass");

    a_store_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STORE) |-> ($past(r_state) == S_DIV_STEP))
        else $error("quotient stored without division steps");

    a_load_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> (r_state == S_OUT && r_ridx == RIDX_W'(NUM_RATIOS - 1)))
        else $error("result loaded before all ratios were done");

endmodule

// File: sv/lccop_datapath.sv
`timescale 1ns / 1ps
module lccop_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lccop_pkg::t_cmd     i_cmd,
    input  lccop_pkg::t_cfg     i_cfg,
    input  lccop_pkg::t_in_item i_item,
    output lccop_pkg::t_status  o_status,
    output lccop_pkg::t_out_item o_result
);
    import lccop_pkg::*;

    t_in_item                  r_item;
    logic signed [RAW_W-1:0]   r_raw  [NUM_SENSORS];
    logic signed [F_W-1:0]     r_f    [NUM_SENSORS];
    logic signed [RAW_W-1:0]   r_zero [NUM_SENSORS];
    logic signed [TARE_W-1:0]  r_tare [NUM_SENSORS];
    logic signed [W_W-1:0]     r_w;
    logic signed [MOM_W-1:0]   r_mxr, r_myr, r_mxl, r_myl;
    logic signed [BAL_W-1:0]   r_bal  [3];
    logic [W_W-1:0]            r_den;
    logic                      r_den_zero;
    logic [NUM_W-1:0]          r_rem;
    logic                      r_neg;
    logic [QUO_BITS-1:0]       r_q;
    logic signed [RES_W-1:0]   r_res  [NUM_RATIOS];

    logic [ADC_BITS-1:0]       w_samp [NUM_SENSORS];
    logic [OFF_BITS-1:0]       w_off;
    logic [GAIN_BITS-1:0]      w_gain;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [RAW_W-1:0]   w_raw;
    logic signed [F_W-1:0]     w_f;
    logic signed [POS_BITS-1:0] w_x, w_y;
    logic signed [PROD_W-1:0]  w_px, w_py;
    logic signed [NUM_W-1:0]   w_num;
    logic [STEP_W-1:0]         w_k;
    logic [NUM_W-1:0]          w_sh;
    logic [17:0]               w_mag, w_lim, w_val;
    logic [RES_W-1:0]          w_res;
    logic [95:0]               w_off_all;
    logic [127:0]              w_gain_all;

    assign w_samp[0] = r_item.sample_0;
    assign w_samp[1] = r_item.sample_1;
    assign w_samp[2] = r_item.sample_2;
    assign w_samp[3] = r_item.sample_3;
    assign w_samp[4] = r_item.sample_4;
    assign w_samp[5] = r_item.sample_5;
    assign w_samp[6] = r_item.sample_6;
    assign w_samp[7] = r_item.sample_7;

    assign w_off_all  = {i_cfg.off_hi, i_cfg.off_lo};
    assign w_gain_all = {i_cfg.gain_hi, i_cfg.gain_lo};
    assign w_off      = w_off_all[i_cmd.ch*OFF_BITS +: OFF_BITS];
    assign w_gain     = w_gain_all[i_cmd.ch*GAIN_BITS +: GAIN_BITS];

    assign w_diff = $signed(DIFF_W'(w_samp[i_cmd.ch])) - $signed(DIFF_W'(w_off));
    assign w_raw  = RAW_W'(w_diff) * $signed(RAW_W'({1'b0, w_gain}));

    assign w_f = F_W'(r_raw[i_cmd.ch]) - F_W'(r_zero[i_cmd.ch]) - F_W'(r_tare[i_cmd.ch]);

    assign w_x  = $signed(i_cfg.xpos[i_cmd.ch*POS_BITS +: POS_BITS]);
    assign w_y  = $signed(i_cfg.ypos[i_cmd.ch*POS_BITS +: POS_BITS]);
    assign w_px = PROD_W'(r_f[i_cmd.ch]) * PROD_W'(w_x);
    assign w_py = PROD_W'(r_f[i_cmd.ch]) * PROD_W'(w_y);

    // numerator for the ratio in flight
    always_comb begin
        unique case (i_cmd.ridx)
            R_LAT:   w_num = NUM_W'(r_bal[0]) <<< BAL_SHIFT;
            R_FA:    w_num = NUM_W'(r_bal[1]) <<< BAL_SHIFT;
            R_TW:    w_num = NUM_W'(r_bal[2]) <<< BAL_SHIFT;
            R_CX:    w_num = (NUM_W'(r_mxr) + NUM_W'(r_mxl)) <<< CEN_SHIFT;
            R_CY:    w_num = (NUM_W'(r_myr) + NUM_W'(r_myl)) <<< CEN_SHIFT;
            R_ROT:   w_num = (NUM_W'(r_myr) - NUM_W'(r_myl)) <<< CEN_SHIFT;
            R_LX:    w_num = NUM_W'(r_mxl) <<< CEN_SHIFT;
            R_LY:    w_num = NUM_W'(r_myl) <<< CEN_SHIFT;
            R_RX:    w_num = NUM_W'(r_mxr) <<< CEN_SHIFT;
            R_RY:    w_num = NUM_W'(r_myr) <<< CEN_SHIFT;
            default: w_num = '0;
        endcase
    end

    assign w_k  = STEP_W'(QUO_BITS - 1) - i_cmd.step;
    assign w_sh = NUM_W'(r_den) << w_k;

    // saturate and sign the quotient, zero for a zero denominator; top quotient bit means far out of range
    always_comb begin
        w_mag = 18'(r_q);
        if (i_cmd.ridx <= R_TW)  w_lim = BAL_LIM;
        else if (r_neg)          w_lim = CEN_NEG_LIM;
        else                     w_lim = CEN_POS_LIM;
        w_val = (w_mag > w_lim) ? w_lim : w_mag;
        if (r_den_zero)          w_res = '0;
        else if (r_neg)          w_res = RES_W'(-w_val);
        else                     w_res = RES_W'(w_val);
    end

    // measure and unused opcodes leave the stored forces alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_zero[i] <= '0;
                r_tare[i] <= '0;
            end
        end else if (i_cmd.force_step) begin
            if (r_item.opcode == OP_CAL) begin
                r_zero[i_cmd.ch] <= r_raw[i_cmd.ch];
            end else if (r_item.opcode == OP_TARE) begin
                r_tare[i_cmd.ch] <= TARE_W'(r_raw[i_cmd.ch]) - TARE_W'(r_zero[i_cmd.ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
            r_w    <= '0;
            r_mxr  <= '0;
            r_myr  <= '0;
            r_mxl  <= '0;
            r_myl  <= '0;
        end
        if (i_cmd.raw_step) begin
            r_raw[i_cmd.ch] <= w_raw;
            r_w             <= r_w + W_W'(w_raw);
        end
        if (i_cmd.force_step) begin
            r_f[i_cmd.ch] <= w_f;
        end
        if (i_cmd.mom_step) begin
            if (i_cmd.ch[CH_W-1]) begin
                r_mxl <= r_mxl + MOM_W'(w_px);
                r_myl <= r_myl + MOM_W'(w_py);
            end else begin
                r_mxr <= r_mxr + MOM_W'(w_px);
                r_myr <= r_myr + MOM_W'(w_py);
            end
        end
        if (i_cmd.sums) begin
            r_bal[0] <= BAL_W'(r_f[0]) + BAL_W'(r_f[1]) + BAL_W'(r_f[2]) + BAL_W'(r_f[3])
                      - BAL_W'(r_f[4]) - BAL_W'(r_f[5]) - BAL_W'(r_f[6]) - BAL_W'(r_f[7]);
            r_bal[1] <= BAL_W'(r_f[2]) + BAL_W'(r_f[3]) + BAL_W'(r_f[4]) + BAL_W'(r_f[5])
                      - BAL_W'(r_f[0]) - BAL_W'(r_f[1]) - BAL_W'(r_f[6]) - BAL_W'(r_f[7]);
            r_bal[2] <= BAL_W'(r_f[0]) + BAL_W'(r_f[1]) + BAL_W'(r_f[4]) + BAL_W'(r_f[5])
                      - BAL_W'(r_f[2]) - BAL_W'(r_f[3]) - BAL_W'(r_f[6]) - BAL_W'(r_f[7]);
            r_den      <= r_w[W_W-1] ? W_W'(-r_w) : W_W'(r_w);
            r_den_zero <= (r_w == '0);
        end
        if (i_cmd.div_load) begin
            r_rem <= w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
            r_neg <= w_num[NUM_W-1] ^ r_w[W_W-1];
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_rem >= w_sh) begin
                r_rem    <= r_rem - w_sh;
                r_q[w_k] <= 1'b1;
            end
        end
        if (i_cmd.div_store) begin
            r_res[i_cmd.ridx] <= $signed(w_res);
        end
    end

    assign o_status.op = t_op'(r_item.opcode);

    assign o_result.lateral_balance  = r_res[R_LAT];
    assign o_result.fore_aft_balance = r_res[R_FA];
    assign o_result.twist_balance    = r_res[R_TW];
    assign o_result.center_x         = r_res[R_CX];
    assign o_result.center_y         = r_res[R_CY];
    assign o_result.center_rotation  = r_res[R_ROT];
    assign o_result.left_center_x    = r_res[R_LX];
    assign o_result.left_center_y    = r_res[R_LY];
    assign o_result.right_center_x   = r_res[R_RX];
    assign o_result.right_center_y   = r_res[R_RY];
    assign o_result.total_weight     = r_w[WEIGHT_W-1:0];
    assign o_result.fall_flag        = (NUM_W'(r_w) < $signed(NUM_W'({1'b0, i_cfg.fall})));

endmodule

// File: tb/tb_load_cell_center_of_pressure_top.sv
`timescale 1ns / 1ps
module tb_load_cell_center_of_pressure_top;
    import lccop_pkg::*;

    localparam int IDLE_AFTER = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    load_cell_center_of_pressure_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of configuration and stored forces
    logic [47:0] cal_off_lo, cal_off_hi;
    logic [63:0] cal_gain_lo, cal_gain_hi, cal_xpos, cal_ypos;
    logic [30:0] cal_fall;
    longint      zero_force [8];
    longint      tare_force [8];

    t_out_item   pending_cop [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;
    bit          failed;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // the receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: count cycles in which no handshake completes
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cop.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_item);
                failed = 1'b1;
            end else begin
                want = pending_cop.pop_front();
                if (want !== o_out_item) begin
                    $display("%0t: expected %h actual %h", $time, want, o_out_item);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic longint quot_clamp(longint num, longint den, longint lo, longint hi);
        longint q;
        if (den == 0)
            return 0;
        q = num / den;
        if (q < lo)
            q = lo;
        if (q > hi)
            q = hi;
        return q;
    endfunction

    // model one request; push the expected result of a measure
    task automatic predict_cop(t_in_item req);
        longint raw [8];
        longint f [8];
        longint w, mxr, myr, mxl, myl, fr, fl, ffr, fbk, fcw, fccw, x, y;
        logic [11:0] smp [8];
        logic [47:0] offs;
        logic [63:0] gains;
        t_out_item res;
        w = 0; mxr = 0; myr = 0; mxl = 0; myl = 0;
        smp = '{req.sample_0, req.sample_1, req.sample_2, req.sample_3,
                req.sample_4, req.sample_5, req.sample_6, req.sample_7};
        if (t_op'(req.opcode) == OP_NONE)
            return;
        for (int i = 0; i < 8; i++) begin
            offs  = (i < 4) ? cal_off_lo : cal_off_hi;
            gains = (i < 4) ? cal_gain_lo : cal_gain_hi;
            raw[i] = (longint'(smp[i]) - longint'(offs[(i % 4) * 12 +: 12]))
                     * longint'(gains[(i % 4) * 16 +: 16]);
            w += raw[i];
        end
        if (t_op'(req.opcode) == OP_CAL) begin
            foreach (raw[i]) zero_force[i] = raw[i];
            return;
        end
        if (t_op'(req.opcode) == OP_TARE) begin
            foreach (raw[i]) tare_force[i] = raw[i] - zero_force[i];
            return;
        end
        for (int i = 0; i < 8; i++) begin
            x = longint'($signed(cal_xpos[i * 8 +: 8]));
            y = longint'($signed(cal_ypos[i * 8 +: 8]));
            f[i] = raw[i] - zero_force[i] - tare_force[i];
            if (i < 4) begin
                mxr += f[i] * x; myr += f[i] * y;
            end else begin
                mxl += f[i] * x; myl += f[i] * y;
            end
        end
        fr = f[0] + f[1] + f[2] + f[3];
        fl = f[4] + f[5] + f[6] + f[7];
        ffr = f[2] + f[3] + f[4] + f[5];
        fbk = f[0] + f[1] + f[6] + f[7];
        fcw = f[0] + f[1] + f[4] + f[5];
        fccw = f[2] + f[3] + f[6] + f[7];
        res.lateral_balance  = 16'(quot_clamp((fr - fl) * 16384, w, -16384, 16384));
        res.fore_aft_balance = 16'(quot_clamp((ffr - fbk) * 16384, w, -16384, 16384));
        res.twist_balance    = 16'(quot_clamp((fcw - fccw) * 16384, w, -16384, 16384));
        res.center_x         = 16'(quot_clamp((mxr + mxl) * 256, w, -32768, 32767));
        res.center_y         = 16'(quot_clamp((myr + myl) * 256, w, -32768, 32767));
        res.center_rotation  = 16'(quot_clamp((myr - myl) * 256, w, -32768, 32767));
        res.left_center_x    = 16'(quot_clamp(mxl * 256, w, -32768, 32767));
        res.left_center_y    = 16'(quot_clamp(myl * 256, w, -32768, 32767));
        res.right_center_x   = 16'(quot_clamp(mxr * 256, w, -32768, 32767));
        res.right_center_y   = 16'(quot_clamp(myr * 256, w, -32768, 32767));
        res.total_weight     = 32'(w);
        res.fall_flag        = (w < longint'(cal_fall));
        pending_cop.push_back(res);
    endtask

    // send one request, idling at random before it; drop valid for a cycle after
    task automatic send_request(t_op op, logic [95:0] smp);
        t_in_item req;
        req = {op, smp};
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        predict_cop(req);
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every measure has produced its result, then let the block settle
    task automatic drain_results();
        while (pending_cop.size() != 0) @(posedge i_clk);
        repeat (IDLE_AFTER) @(posedge i_clk);
    endtask

    // write one register through the config port: setup, access, then idle
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_OFF_LO:  cal_off_lo  = value[47:0];
            REG_OFF_HI:  cal_off_hi  = value[47:0];
            REG_GAIN_LO: cal_gain_lo = value;
            REG_GAIN_HI: cal_gain_hi = value;
            REG_XPOS:    cal_xpos    = value;
            REG_YPOS:    cal_ypos    = value;
            REG_FALL:    cal_fall    = value[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random settings use small offsets and full random gains; extreme ones use limit values
    task automatic load_setting(bit extreme);
        drain_results();
        write_reg(REG_OFF_LO,  extreme ? 64'hFFFF_FFFF_FFFF : rand64() & 64'h0FF_0FF_0FF_0FF);
        write_reg(REG_OFF_HI,  extreme ? 64'h0 : rand64() & 64'h0FF_0FF_0FF_0FF);
        write_reg(REG_GAIN_LO, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
        write_reg(REG_GAIN_HI, extreme ? 64'h0001_0001_0001_0001 : rand64());
        write_reg(REG_XPOS,    extreme ? 64'h8080_7F7F_8080_7F7F : rand64());
        write_reg(REG_YPOS,    extreme ? 64'h7F80_7F80_7F80_7F80 : rand64());
        write_reg(REG_FALL,    extreme ? 64'h7FFF_FFFF : 64'($urandom_range(200000)));
    endtask

    function automatic logic [95:0] rand_frame();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // extremes of samples, every opcode, zero weight and negative weight
    task automatic test_directed();
        send_request(OP_MEASURE, '0);               // zero weight before any config
        load_setting(1'b1);
        send_request(OP_MEASURE, '1);
        send_request(OP_MEASURE, '0);               // negative weight
        send_request(OP_NONE, rand_frame());
        send_request(OP_CAL, '1);
        send_request(OP_MEASURE, '1);               // zero forces cancel
        send_request(OP_TARE, {8{12'h800}});
        send_request(OP_MEASURE, {8{12'hFFF}});
        send_request(OP_MEASURE, {12'hFFF, 12'h0, 12'hFFF, 12'h0,
                                  12'h0, 12'hFFF, 12'h0, 12'hFFF});
        send_request(OP_CAL, '0);
        send_request(OP_TARE, '0);
        send_request(OP_MEASURE, rand_frame());
        load_setting(1'b0);
        send_request(OP_CAL, '0);
        send_request(OP_TARE, '0);
        send_request(OP_MEASURE, {8{12'hAAA}});
        send_request(OP_MEASURE, {8{12'h555}});
        // hold off until every result is in
        drain_results();
    endtask

    // mostly measures; occasional calibrate, tare and unused opcode
    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 59)
                load_setting($urandom_range(4) == 0);
            pick = $urandom_range(99);
            if (pick < 80)
                send_request(OP_MEASURE, rand_frame());
            else if (pick < 88)
                send_request(OP_TARE, rand_frame());
            else if (pick < 95)
                send_request(OP_CAL, rand_frame());
            else
                send_request(OP_NONE, rand_frame());
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_item = '0; i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quiet_cycles = 0; failed = 1'b0;
        send_idle_pct = 9; recv_idle_pct = 79;
        cal_off_lo = '0; cal_off_hi = '0; cal_gain_lo = '0; cal_gain_hi = '0;
        cal_xpos = '0; cal_ypos = '0; cal_fall = FALL_RESET;
        foreach (zero_force[i]) begin
            zero_force[i] = 0; tare_force[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(160);
        send_idle_pct = 79; recv_idle_pct = 9;
        test_random(160);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(160);

        drain_results();
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
